// ===== hdl/rpn_pkg.sv =====
// Shared types, constants and codes for the RPN expression evaluator.
package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_SYNTAX = 3'd1;
   localparam logic [2:0] ST_UNDER  = 3'd2;
   localparam logic [2:0] ST_MANY   = 3'd3;
   localparam logic [2:0] ST_DIVZ   = 3'd4;
   localparam logic [2:0] ST_EMPTY  = 3'd5;
   localparam logic [2:0] ST_OVER   = 3'd6;

   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_Q     = 8'h71;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;

   localparam logic [1:0] OP_DIV  = 2'd0;
   localparam logic [1:0] OP_ROOT = 2'd1;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [2:0]         status;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [31:0] a;
      logic [31:0] b;
   } iter_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } iter_rsp_type;

endpackage

// ===== hdl/rpn_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hdl/rpn_iter.sv =====
// Shared bit-serial unit: unsigned divide and floor square root.
module rpn_iter (
   input  logic                  clock,
   input  logic                  reset,
   input  rpn_pkg::iter_cmd_type cmd,
   output rpn_pkg::iter_rsp_type rsp
);
   import rpn_pkg::*;

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [63:0] x_ff, x_in;
   logic [32:0] trial;
   logic [33:0] rtrial;
   logic [33:0] rshift;
   logic        done_ff, done_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      x_in    = x_ff;
      done_in = 1'b0;
      trial   = {r_ff[31:0], q_ff[31]} - {1'b0, d_ff};
      rshift  = {r_ff[31:0], x_ff[63:62]};
      rtrial  = rshift - {q_ff, 2'b01};
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         op_in   = cmd.op;
         q_in    = (cmd.op == OP_DIV) ? cmd.a : 32'd0;
         r_in    = 33'd0;
         d_in    = cmd.b;
         x_in    = {cmd.a, 32'd0};
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            if (!trial[32]) begin
               r_in = trial;
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               r_in = {r_ff[31:0], q_ff[31]};
               q_in = {q_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            x_in = {x_ff[61:0], 2'b00};
            if (!rtrial[33]) begin
               r_in = rtrial[32:0];
               q_in = {q_ff[30:0], 1'b1};
            end else begin
               r_in = rshift[32:0];
               q_in = {q_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      op_ff  <= op_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      x_ff   <= x_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = q_ff;
endmodule

// ===== hdl/rpn_expression_evaluator.sv =====
// Top level of the RPN expression evaluator: sequencer, stack and result register.
//
// Requests carry one character of a reverse-Polish line and a last flag.
// req_stall rises the cycle after a request is taken and holds while the
// character is worked: a digit, space or letter passes through S_CHAR only,
// + and - go on through S_RDB, S_RDA, S_GETA and S_EXEC, * adds S_MUL, sqrt
// waits on 16 steps of the shared serial unit and a divide on 32 steps of
// the same unit. A zero divisor ends a divide early, a negative root ends
// sqrt early. Characters after a fatal error are dropped with no stall,
// the last one apart. The divide sets the worst case. On the character
// flagged last one response is made with the top value and a status through
// S_END, S_RD0 and S_OUT; the line state then clears for the next expression.
// The response sits in an output register; a request may be taken while
// it waits, but a character that makes a new response waits until the
// held one is taken by a low rsp_stall.
// Reset is synchronous, active high, clears the stack count, number and
// error state, and empties the response register. Stack entries above the
// count are never read, so the stack RAM needs no clearing.
module rpn_expression_evaluator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rpn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rpn_pkg::rsp_type rsp_data
);
   import rpn_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CHAR  = 4'd1;
   localparam logic [3:0] S_RDB   = 4'd2;
   localparam logic [3:0] S_RDA   = 4'd3;
   localparam logic [3:0] S_GETA  = 4'd4;
   localparam logic [3:0] S_EXEC  = 4'd5;
   localparam logic [3:0] S_WAIT  = 4'd6;
   localparam logic [3:0] S_END   = 4'd7;
   localparam logic [3:0] S_RD0   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_MUL   = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [7:0]       ch_ff, ch_in;
   logic             last_ff, last_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      acc_ff, acc_in;
   logic             innum_ff, innum_in;
   logic [1:0]       phase_ff, phase_in;
   logic [2:0]       err_ff, err_in;
   logic             skip_ff, skip_in;
   logic [31:0]      a_ff, a_in, b_ff, b_in;
   logic             neg_ff, neg_in;
   logic [63:0]      prod_ff, prod_in;
   logic             rv_ff, rv_in;
   rsp_type          rd_ff, rd_in;

   logic             we;
   logic [SP_W-1:0]  wa, ra;
   logic [31:0]      wd, rdata;
   iter_cmd_type     icmd;
   iter_rsp_type     irsp;

   logic [35:0]      n10;
   logic [32:0]      sum, dif;
   logic [31:0]      ua, ub, uq;
   logic [32:0]      sq;
   logic             push_ok;
   logic [2:0]       st;

   rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rdata)
   );

   rpn_iter u_iter (.clock(clock), .reset(reset), .cmd(icmd), .rsp(irsp));

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;
   assign push_ok   = (cnt_ff < CNT_W'(STACK_DEPTH));

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      last_in  = last_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      innum_in = innum_ff;
      phase_in = phase_ff;
      err_in   = err_ff;
      skip_in  = skip_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      rv_in    = rv_ff & rsp_stall;
      rd_in    = rd_ff;
      we       = 1'b0;
      wa       = cnt_ff[SP_W-1:0];
      wd       = acc_ff;
      ra       = cnt_ff[SP_W-1:0] - SP_W'(1);
      icmd     = '0;
      n10      = {4'd0, acc_ff} * 36'd10 + {28'd0, ch_ff - CH_ZERO};
      sum      = {a_ff[31], a_ff} + {b_ff[31], b_ff};
      dif      = {a_ff[31], a_ff} - {b_ff[31], b_ff};
      ua       = a_ff[31] ? -a_ff : a_ff;
      ub       = b_ff[31] ? -b_ff : b_ff;
      uq       = neg_ff ? -irsp.result : irsp.result;
      sq       = {1'b0, prod_ff[31:0]};
      st       = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ch_in    = req_data.char_code;
               last_in  = req_data.last_char;
               state_in = skip_ff ? (req_data.last_char ? S_END : S_IDLE) : S_CHAR;
            end
         end
         S_CHAR: begin
            state_in = last_ff ? S_END : S_IDLE;
            if (phase_ff != 2'd0) begin
               if ((phase_ff == 2'd1 && ch_ff != CH_Q) ||
                   (phase_ff == 2'd2 && ch_ff != CH_R) ||
                   (phase_ff == 2'd3 && ch_ff != CH_T)) begin
                  err_in  = ST_SYNTAX;
                  skip_in = 1'b1;
               end else if (phase_ff == 2'd3) begin
                  phase_in = 2'd0;
                  if (cnt_ff == '0) begin
                     err_in  = ST_UNDER;
                     skip_in = 1'b1;
                  end else begin
                     state_in = S_RDB;
                     ch_in    = CH_S;
                  end
               end else begin
                  phase_in = phase_ff + 2'd1;
               end
            end else if (ch_ff >= CH_ZERO && ch_ff <= CH_NINE) begin
               innum_in = 1'b1;
               if (!innum_ff) begin
                  n10 = {28'd0, ch_ff - CH_ZERO};
               end
               if (n10 > 36'h07FFFFFFF) begin
                  err_in  = ST_OVER;
                  skip_in = 1'b1;
               end else begin
                  acc_in = n10[31:0];
               end
            end else begin
               if (innum_ff) begin
                  innum_in = 1'b0;
                  acc_in   = '0;
                  if (push_ok) begin
                     we     = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end else begin
                     err_in  = ST_OVER;
                     skip_in = 1'b1;
                  end
               end
               if (!(innum_ff && !push_ok) && ch_ff != CH_SPACE) begin
                  if (ch_ff == CH_PLUS || ch_ff == CH_MINUS ||
                      ch_ff == CH_STAR || ch_ff == CH_SLASH) begin
                     if (cnt_in < CNT_W'(2)) begin
                        err_in  = ST_UNDER;
                        skip_in = 1'b1;
                     end else begin
                        state_in = S_RDB;
                     end
                  end else if (ch_ff == CH_S) begin
                     phase_in = 2'd1;
                  end else begin
                     err_in  = ST_SYNTAX;
                     skip_in = 1'b1;
                  end
               end
            end
         end
         S_RDB: begin
            state_in = S_RDA;
         end
         S_RDA: begin
            b_in     = rdata;
            ra       = cnt_ff[SP_W-1:0] - SP_W'(2);
            state_in = (ch_ff == CH_S) ? S_EXEC : S_GETA;
         end
         S_GETA: begin
            a_in     = rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_WAIT;
            if (ch_ff == CH_S) begin
               if (b_ff[31]) begin
                  we       = 1'b1;
                  wa       = cnt_ff[SP_W-1:0] - SP_W'(1);
                  wd       = '0;
                  state_in = last_ff ? S_END : S_IDLE;
               end else begin
                  icmd.start = 1'b1;
                  icmd.op    = OP_ROOT;
                  icmd.a     = b_ff;
               end
            end else if (ch_ff == CH_SLASH) begin
               cnt_in = cnt_ff - CNT_W'(1);
               if (b_ff == '0) begin
                  we = 1'b1;
                  wa = cnt_ff[SP_W-1:0] - SP_W'(2);
                  wd = '0;
                  if (err_ff == ST_OK) begin
                     err_in = ST_DIVZ;
                  end
                  state_in = last_ff ? S_END : S_IDLE;
               end else begin
                  neg_in     = a_ff[31] ^ b_ff[31];
                  icmd.start = 1'b1;
                  icmd.op    = OP_DIV;
                  icmd.a     = ua;
                  icmd.b     = ub;
               end
            end else if (ch_ff == CH_STAR) begin
               prod_in  = $signed(a_ff) * $signed(b_ff);
               state_in = S_MUL;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = last_ff ? S_END : S_IDLE;
               if (ch_ff == CH_PLUS) begin
                  sq = sum;
               end else begin
                  sq = dif;
               end
               if (sq[32] != sq[31]) begin
                  err_in  = ST_OVER;
                  skip_in = 1'b1;
               end else begin
                  we = 1'b1;
                  wa = cnt_ff[SP_W-1:0] - SP_W'(2);
                  wd = sq[31:0];
               end
            end
         end
         S_MUL: begin
            cnt_in   = cnt_ff - CNT_W'(1);
            state_in = last_ff ? S_END : S_IDLE;
            if (prod_ff[63:31] != {33{prod_ff[31]}}) begin
               err_in  = ST_OVER;
               skip_in = 1'b1;
            end else begin
               we = 1'b1;
               wa = cnt_ff[SP_W-1:0] - SP_W'(2);
               wd = prod_ff[31:0];
            end
         end
         S_WAIT: begin
            if (irsp.done) begin
               state_in = last_ff ? S_END : S_IDLE;
               we       = 1'b1;
               wa       = cnt_ff[SP_W-1:0] - SP_W'(1);
               if (ch_ff == CH_S) begin
                  wd = irsp.result;
               end else if (uq[31] != neg_ff && uq != '0) begin
                  err_in  = ST_OVER;
                  skip_in = 1'b1;
                  we      = 1'b0;
               end else begin
                  wd = uq;
               end
            end
         end
         S_END: begin
            state_in = S_RD0;
            ra       = '0;
            if (!skip_ff) begin
               if (innum_ff) begin
                  innum_in = 1'b0;
                  if (push_ok) begin
                     we     = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end else begin
                     err_in  = ST_OVER;
                     skip_in = 1'b1;
                  end
               end else if (phase_ff != 2'd0) begin
                  err_in  = ST_SYNTAX;
                  skip_in = 1'b1;
               end
            end
         end
         S_RD0: begin
            ra       = '0;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               if (err_ff == ST_SYNTAX || err_ff == ST_UNDER || err_ff == ST_OVER) begin
                  st = err_ff;
               end else if (cnt_ff > CNT_W'(1)) begin
                  st = ST_MANY;
               end else if (err_ff == ST_DIVZ) begin
                  st = ST_DIVZ;
               end else if (cnt_ff == '0) begin
                  st = ST_EMPTY;
               end else begin
                  st = ST_OK;
               end
               rv_in              = 1'b1;
               rd_in.status       = st;
               rd_in.result_value = (st == ST_OK) ? rdata : '0;
               cnt_in   = '0;
               acc_in   = '0;
               innum_in = 1'b0;
               phase_in = 2'd0;
               err_in   = ST_OK;
               skip_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         innum_ff <= 1'b0;
         phase_ff <= 2'd0;
         err_ff   <= ST_OK;
         skip_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         innum_ff <= innum_in;
         phase_ff <= phase_in;
         err_ff   <= err_in;
         skip_ff  <= skip_in;
         rv_ff    <= rv_in;
      end
      ch_ff   <= ch_in;
      last_ff <= last_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      rd_ff   <= rd_in;
   end
endmodule
